FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/kths_pkg.sv
`timescale 1ns / 1ps

package kths_pkg;

   localparam int K_MAX   = 16;
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 5;
   localparam int IDX_W   = $clog2(K_MAX);
   localparam int CNT_W   = $clog2(K_MAX + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index, decoded from the word address bit.
   localparam logic CSR_IDX_RANK = 1'b0;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic {
      ST_RUN,
      ST_HOLD
   } ctl_state_type;

   typedef struct packed {
      logic accept;       // an input item is transferred this cycle
      logic load_result;  // capture the finished set's result in the output register
   } ctl_cmd_type;

   // Index of the kth entry: rank zero acts as rank one, large ranks saturate.
   function automatic logic [IDX_W-1:0] eff_k_idx(input logic [RANK_W-1:0] rank);
      logic [IDX_W-1:0] idx;
      if (rank == '0) begin
         idx = '0;
      end else if (int'(rank) > K_MAX) begin
         idx = IDX_W'(K_MAX - 1);
      end else begin
         idx = IDX_W'(rank - RANK_W'(1));
      end
      return idx;
   endfunction

endpackage

FILE: design/kths_ctl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kths_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output kths_pkg::ctl_cmd_type  cmd
);
   import kths_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      // A last item may only enter when the output register is free or drains now.
      req_tready = !((state_ff == ST_HOLD) && !rsp_tready && req_tlast);
      rsp_tvalid = (state_ff == ST_HOLD);
      take       = req_tvalid && req_tready;
      cmd.accept      = take;
      cmd.load_result = take && req_tlast;
      state_in   = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (cmd.load_result) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_tready && !cmd.load_result) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   `ASSERT_CLK(a_no_overwrite, !((state_ff == ST_HOLD) && !rsp_tready && cmd.load_result), "pending result overwritten")
   `ASSERT_CLK(a_last_to_hold, cmd.load_result |=> (state_ff == ST_HOLD), "result not presented after last item")
   `ASSERT_CLK(a_drain_to_run, ((state_ff == ST_HOLD) && rsp_tready && !cmd.load_result) |=> (state_ff == ST_RUN), "taken result still shown")
   `ASSERT_CLK(a_load_is_last, cmd.load_result |-> (req_tlast && cmd.accept), "result loaded without last item")

endmodule

FILE: design/kths_dp.sv
`timescale 1ns / 1ps

module kths_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  kths_pkg::ctl_cmd_type         cmd,
   input  logic [kths_pkg::VALUE_W-1:0]  in_value,
   input  logic                          in_last,
   input  logic [kths_pkg::IDX_W-1:0]    k_idx,
   output logic [kths_pkg::VALUE_W-1:0]  out_kth_value,
   output logic                          out_too_few
);
   import kths_pkg::*;

   // Sorted chain of cells, ascending; only the first kept_cnt_ff entries are meaningful.
   value_type        cell_ff [K_MAX];
   value_type        cell_in [K_MAX];
   logic [CNT_W-1:0] kept_cnt_ff, kept_cnt_in;
   logic [VALUE_W-1:0] kth_ff, kth_in;
   logic             too_few_ff, too_few_in;

   value_type        v;
   logic [K_MAX-1:0] gt;
   logic [CNT_W-1:0] k_val, cnt_eff, cnt_new;

   always_comb begin
      v     = value_type'(in_value);
      k_val = CNT_W'(k_idx) + CNT_W'(1);
      // Shrink to the current rank if it was lowered during the set.
      cnt_eff = (kept_cnt_ff > k_val) ? k_val : kept_cnt_ff;
      // A cell moves when it is empty or holds a strictly larger value.
      for (int i = 0; i < K_MAX; i++) begin
         gt[i] = (CNT_W'(i) >= cnt_eff) || (cell_ff[i] > v);
      end
      cell_in[0] = gt[0] ? v : cell_ff[0];
      for (int i = 1; i < K_MAX; i++) begin
         if (!gt[i]) begin
            cell_in[i] = cell_ff[i];
         end else if (gt[i-1]) begin
            cell_in[i] = cell_ff[i-1];
         end else begin
            cell_in[i] = v;
         end
      end
      // A full store takes the value only when it beats the kth entry; the largest drops off.
      cnt_new    = (cnt_eff < k_val) ? cnt_eff + CNT_W'(1) : cnt_eff;
      too_few_in = (cnt_new < k_val);
      kth_in     = too_few_in ? '0 : VALUE_W'(cell_in[k_idx]);
      kept_cnt_in = in_last ? '0 : cnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_cnt_ff <= '0;
      end else if (cmd.accept) begin
         kept_cnt_ff <= kept_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !in_last) begin
         cell_ff <= cell_in;
      end
      if (cmd.load_result) begin
         kth_ff     <= kth_in;
         too_few_ff <= too_few_in;
      end
   end

   assign out_kth_value = kth_ff;
   assign out_too_few   = too_few_ff;

endmodule

FILE: design/streaming_kth_smallest_select_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer contents
// req_      in         tdata = value (32b signed), tlast = last of the set
// rsp_      out        tdata = kth_value (32b signed), tuser = too_few
// csr_      APB        offset 0x0: rank_k (5b, reset 1)
//
// One value is taken every cycle; the insert into the sorted cell chain
// finishes in the cycle of the transfer. A set's result appears on rsp_ the
// cycle after its last value is transferred and holds until it is taken.
// While a result waits, values that are not the last of a set still flow in;
// a last value waits until the output register is free or drains that cycle.
// Reset is synchronous and active high; it empties the store and sets rank_k to 1.

module streaming_kth_smallest_select_top (
   input  logic                             clock,
   input  logic                             reset,
   // Input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // [31:0] value
   input  logic                             req_tlast,
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [31:0] kth_value
   output logic [0:0]                       rsp_tuser,   // [0] too_few
   // Configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [kths_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [kths_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [kths_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import kths_pkg::*;

   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              csr_wr;
   ctl_cmd_type       cmd;
   logic [0:0]        too_few;

   // The register is selected by the word address; the byte offset bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rank_in    = (csr_wr && (csr_paddr[2] == CSR_IDX_RANK)) ?
                       csr_pwdata[RANK_W-1:0] : rank_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_RANK) ?
                       CSR_DATA_W'(rank_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_W'(1);
      end else begin
         rank_ff <= rank_in;
      end
   end

   // Controller: handshakes and the output register's occupancy.
   kths_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: the sorted cell chain, fill count and result register.
   kths_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_value      (req_tdata[VALUE_W-1:0]),
      .in_last       (req_tlast),
      .k_idx         (eff_k_idx(rank_ff)),
      .out_kth_value (rsp_tdata),
      .out_too_few   (too_few[0])
   );

   assign rsp_tuser = too_few;

endmodule

FILE: sim/kths_checker.sv
`timescale 1ns / 1ps

module kths_checker
   import kths_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [31:0]            req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [31:0]            rsp_tdata,
   input  logic [0:0]             rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int unsigned            mismatch_count,
   output int unsigned            results_owed
);

   typedef struct packed {
      value_type kth_value;
      logic      too_few;
   } kth_result_type;

   // Kept values of the open set, ascending; only the first kept_n are valid.
   value_type         kept [K_MAX];
   int unsigned       kept_n;
   logic [RANK_W-1:0] rank_reg;
   kth_result_type    kth_owed_q [$];

   function automatic int unsigned active_rank(input logic [RANK_W-1:0] r);
      if (r == '0) begin
         return 1;
      end
      if (int'(r) > K_MAX) begin
         return K_MAX;
      end
      return int'(r);
   endfunction

   task automatic keep_sorted(input value_type v);
      int unsigned pos;
      pos = kept_n;
      while (pos > 0 && kept[pos-1] > v) begin
         kept[pos] = kept[pos-1];
         pos--;
      end
      kept[pos] = v;
      kept_n++;
   endtask

   task automatic absorb_value(input value_type v, input logic lst);
      int unsigned    k;
      kth_result_type res;
      k = active_rank(rank_reg);
      // A rank lowered in the middle of a set trims the largest entries first.
      if (kept_n > k) begin
         kept_n = k;
      end
      if (kept_n < k) begin
         keep_sorted(v);
      end else if (v < kept[k-1]) begin
         kept_n--;
         keep_sorted(v);
      end
      if (lst) begin
         if (kept_n < k) begin
            res.kth_value = '0;
            res.too_few   = 1'b1;
         end else begin
            res.kth_value = kept[k-1];
            res.too_few   = 1'b0;
         end
         kth_owed_q.push_back(res);
         kept_n = 0;
      end
   endtask

   always @(posedge clock) begin
      kth_result_type want;
      int unsigned    bad;
      bad = 0;
      if (reset) begin
         kept_n   = 0;
         rank_reg = RANK_W'(1);
         kth_owed_q.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == CSR_IDX_RANK) begin
            rank_reg = csr_pwdata[RANK_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (kth_owed_q.size() == 0) begin
               $error("unexpected result: kth_value %0d too_few %0d",
                      $signed(rsp_tdata), rsp_tuser[0]);
               bad++;
            end else begin
               want = kth_owed_q.pop_front();
               if ($signed(rsp_tdata) !== want.kth_value) begin
                  $error("kth_value: expected %0d, actual %0d",
                         want.kth_value, $signed(rsp_tdata));
                  bad++;
               end
               if (rsp_tuser[0] !== want.too_few) begin
                  $error("too_few: expected %0d, actual %0d",
                         want.too_few, rsp_tuser[0]);
                  bad++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_value($signed(req_tdata), req_tlast);
         end
         mismatch_count <= mismatch_count + bad;
      end
      results_owed <= kth_owed_q.size();
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import kths_pkg::*;

   // Generous bound on the whole run, counted in clock cycles.
   localparam int unsigned CYCLE_LIMIT   = 200_000;
   // Random items to push after the directed part.
   localparam int unsigned RANDOM_ITEMS  = 600;
   // Cycles to let pass after the last result before a register write or the end.
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef enum int {
      MIX_ANY,
      MIX_NARROW,
      MIX_RAIL
   } value_mix_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;     // [31:0] value
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;     // [31:0] kth_value
   logic [0:0]            rsp_tuser;     // [0] too_few
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count;
   int unsigned items_sent;
   // While quiet is high neither side inserts idle cycles.
   logic        quiet;

   streaming_kth_smallest_select_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The checker sits beside the block, watching every transfer and register write.
   kths_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // The result side stalls on its own schedule, changing only at falling edges,
   // so that back pressure lands on every phase of the block's work.
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 38);
      end
   end

   // Pushes one value and returns at the rising edge where its transfer happens.
   // Idle cycles, if any, come before the item, each with valid held low.
   task automatic send_value(input value_type v, input logic lst);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= lst;
      do begin
         @(posedge clock);
      end while (!req_tready);
      items_sent++;
   endtask

   // Registers change only with the block idle: no value on offer, every owed
   // result taken, and a settling wait of SETTLE_CYCLES before the write.
   task automatic write_rank(input logic [RANK_W-1:0] rank);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_owed != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      // Setup cycle; the upper data bits are noise the register must drop.
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_RANK, 2'b00};
      csr_pwdata  <= {(CSR_DATA_W - RANK_W)'($urandom_range(0,
                        (1 << (CSR_DATA_W - RANK_W)) - 1)), rank};
      // Access cycle: the write lands at the next rising edge.
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic value_type pick_value(input value_mix_type mix);
      value_type v;
      case (mix)
         MIX_NARROW: begin
            // A narrow range forces many ties with the largest kept value.
            v = value_type'($urandom_range(0, 15)) - value_type'(8);
         end
         MIX_RAIL: begin
            case ($urandom_range(0, 5))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = '0;
               3:       v = -32'sd1;
               4:       v = 32'sh8000_0000 + value_type'($urandom_range(0, 7));
               default: v = 32'sh7FFF_FFFF - value_type'($urandom_range(0, 7));
            endcase
         end
         default: begin
            v = value_type'($urandom);
         end
      endcase
      return v;
   endfunction

   // One set of the given length; an open set stops short of its last value,
   // leaving the store partly filled when the rank changes.
   task automatic send_set(input int unsigned len, input logic open_set);
      value_mix_type mix;
      int unsigned   r;
      r = $urandom_range(0, 9);
      mix = (r < 5) ? MIX_ANY : (r < 8) ? MIX_NARROW : MIX_RAIL;
      for (int unsigned i = 0; i < len; i++) begin
         if (r == 9 && $urandom_range(0, 1) == 0) begin
            mix = MIX_ANY;
         end
         send_value(pick_value(mix), !open_set && (i == len - 1));
      end
   endtask

   initial begin
      logic [RANK_W-1:0] rank;
      int unsigned       k;
      int unsigned       len;
      int unsigned       sets;
      int unsigned       phase;
      int unsigned       target;
      int unsigned       pick;

      reset       <= 1'b1;
      quiet       <= 1'b0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      items_sent  = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed part, rank 1 from reset: single-value set at the negative rail,
      // then a set whose smallest value is minus one.
      send_value(32'sh8000_0000, 1'b1);
      send_value(32'sh7FFF_FFFF, 1'b0);
      send_value(-32'sd1, 1'b0);
      send_value('0, 1'b1);

      // Rank 3: a value below the largest kept one pushes that entry out,
      // and a two-value set comes out flagged as too few.
      write_rank(RANK_W'(3));
      send_value(32'sd7, 1'b0);
      send_value(32'sd7, 1'b0);
      send_value(32'sd9, 1'b0);
      send_value(32'sd7, 1'b1);
      send_value(32'sd1, 1'b0);
      send_value(32'sd2, 1'b1);

      // Rank 4 with a set left open, then rank 2 before its last value:
      // the store must drop its largest entries first.
      write_rank(RANK_W'(4));
      send_value(32'sd40, 1'b0);
      send_value(32'sd10, 1'b0);
      send_value(32'sd30, 1'b0);
      send_value(32'sd20, 1'b0);
      send_value(32'sd50, 1'b0);
      write_rank(RANK_W'(2));
      send_value(32'sd25, 1'b1);

      // Rank zero acts as rank one; an oversized rank saturates to the store size.
      write_rank('0);
      send_value(32'sd3, 1'b0);
      send_value(-32'sd3, 1'b1);
      write_rank('1);
      send_value(32'sd5, 1'b1);

      // Random part: phases of sets under one rank each, the extremes first.
      target = items_sent + RANDOM_ITEMS;
      phase  = 0;
      while (items_sent < target) begin
         case (phase)
            0:       rank = RANK_W'(K_MAX);
            1:       rank = '1;
            2:       rank = RANK_W'(K_MAX + 1);
            3:       rank = '0;
            4:       rank = RANK_W'(1);
            5:       rank = RANK_W'(2);
            default: begin
               pick = $urandom_range(0, 9);
               rank = (pick < 8) ? RANK_W'($urandom_range(1, K_MAX))
                                 : RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
            end
         endcase
         write_rank(rank);
         k = (rank == '0) ? 1 : (int'(rank) > K_MAX) ? K_MAX : int'(rank);
         sets = $urandom_range(3, 8);
         for (int unsigned s = 0; s < sets; s++) begin
            // Hold both sides busy for a long unbroken stretch mid-run.
            quiet <= (items_sent >= target - RANDOM_ITEMS + 250)
                     && (items_sent < target - RANDOM_ITEMS + 400);
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               len = (k > 1) ? $urandom_range(1, k - 1) : 1;
            end else if (pick < 8) begin
               len = $urandom_range(k, k + 12);
            end else begin
               len = $urandom_range(k + 13, k + 40);
            end
            // Now and then the phase ends inside a set, before its last value.
            send_set(len, (s == sets - 1) && ($urandom_range(0, 3) == 0));
         end
         phase++;
      end

      // Close any set left open so that every value ends up in a result.
      send_value(pick_value(MIX_ANY), 1'b1);
      @(negedge clock);
      req_tvalid <= 1'b0;
      quiet      <= 1'b0;
      while (results_owed != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES * 4) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/kths_pkg.sv
design/kths_ctl.sv
design/kths_dp.sv
design/streaming_kth_smallest_select_top.sv
sim/kths_checker.sv
sim/tb_top.sv
